FILE: sv/rsa_pkg.sv
// Shared constants, codes and types of the refcounted slot allocator.
package rsa_pkg;

	localparam int TABLE_SLOTS = 64;
	localparam int FLAG_BITS   = 16;
	localparam int SLOT_W      = $clog2(TABLE_SLOTS);
	localparam int HINT_W      = $clog2(TABLE_SLOTS + 1);
	localparam int COUNT_W     = 16;
	localparam int OP_W        = 3;
	localparam int STATUS_W    = 2;
	localparam int CFG_IDX_W   = 1;

	localparam logic [COUNT_W-1:0]   COUNT_MAX    = '1;
	localparam logic [FLAG_BITS-1:0] ACCMODE_BITS = FLAG_BITS'(3);
	localparam logic [FLAG_BITS-1:0] NONBLOCK_BIT = FLAG_BITS'(16'h0800);

	localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
	localparam logic [OP_W-1:0] OP_FILL    = 3'd1;
	localparam logic [OP_W-1:0] OP_RETAIN  = 3'd2;
	localparam logic [OP_W-1:0] OP_RELEASE = 3'd3;
	localparam logic [OP_W-1:0] OP_GETFL   = 3'd4;
	localparam logic [OP_W-1:0] OP_SETFL   = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_USED = 2'd2;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_KEEP_MASK = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_MASK = 1'b1;

	typedef struct packed {
		logic [COUNT_W-1:0]   cnt;
		logic [FLAG_BITS-1:0] flags;
	} entry_t;

	typedef struct packed {
		logic              rd_en;
		logic [SLOT_W-1:0] rd_addr;
		logic              wr_en;
		logic [SLOT_W-1:0] wr_addr;
		entry_t            wr_data;
	} mem_req_t;

endpackage

FILE: sv/rsa_mem.sv
// Slot table memory with per-entry valid bits; invalid entries read as zero.
module rsa_mem (
	input  logic            clk,
	input  logic            arst_n,
	input  rsa_pkg::mem_req_t req,
	output rsa_pkg::entry_t   rd_data
);
	import rsa_pkg::*;

	entry_t                 mem [TABLE_SLOTS];
	entry_t                 rd_data_q;
	logic [TABLE_SLOTS-1:0] valid_q;
	logic                   rd_vld_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= valid_q[req.rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

	// reads and writes are sequenced, never in the same cycle
	a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.rd_en && req.wr_en))
		else $error("read and write issued together");

endmodule

FILE: sv/rsa_ctrl.sv
// Operation sequencer: hint scan, read-modify-write, config and result registers.
module rsa_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [rsa_pkg::OP_W-1:0]        op,
	input  logic [rsa_pkg::SLOT_W-1:0]      slot,
	input  logic [rsa_pkg::FLAG_BITS-1:0]   flags_in,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rsa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rsa_pkg::FLAG_BITS-1:0]   cfg_data,
	output rsa_pkg::mem_req_t               req,
	input  rsa_pkg::entry_t                 rd_data,
	output logic                            done,
	output logic [rsa_pkg::STATUS_W-1:0]    status,
	output logic [rsa_pkg::SLOT_W-1:0]      slot_out,
	output logic [rsa_pkg::FLAG_BITS-1:0]   flags_out,
	output logic                            freed
);
	import rsa_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_RMW  = 2'd2;
	localparam logic [1:0] S_FULL = 2'd3;

	localparam logic [HINT_W-1:0] HINT_FULL = HINT_W'(TABLE_SLOTS);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

	logic [1:0]           state_q, state_d;
	logic [HINT_W-1:0]    hint_q, hint_d;
	logic [SLOT_W-1:0]    cur_q, cur_d;
	logic [OP_W-1:0]      op_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [FLAG_BITS-1:0] fin_q;
	logic [FLAG_BITS-1:0] keep_mask_q;
	logic [FLAG_BITS-1:0] open_mask_q;

	logic                 done_q;
	logic [STATUS_W-1:0]  status_q;
	logic [SLOT_W-1:0]    slot_out_q;
	logic [FLAG_BITS-1:0] flags_q;
	logic                 freed_q;

	logic                 res_vld;
	logic [STATUS_W-1:0]  res_status;
	logic [SLOT_W-1:0]    res_slot;
	logic [FLAG_BITS-1:0] res_flags;
	logic                 res_freed;

	logic                 accept;
	logic                 known_op;
	logic                 out_range;
	entry_t               upd;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign known_op  = (op_q <= OP_SETFL);
	assign out_range = (HINT_W'(slot_q) >= HINT_FULL);

	always_comb begin
		state_d    = state_q;
		hint_d     = hint_q;
		cur_d      = cur_q;
		req        = '0;
		res_vld    = 1'b0;
		res_status = ST_OK;
		res_slot   = slot_q;
		res_flags  = '0;
		res_freed  = 1'b0;
		upd        = rd_data;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (op == OP_ALLOC) begin
						if (hint_q == HINT_FULL) begin
							state_d = S_FULL;
						end else begin
							req.rd_en   = 1'b1;
							req.rd_addr = hint_q[SLOT_W-1:0];
							cur_d       = hint_q[SLOT_W-1:0];
							state_d     = S_SCAN;
						end
					end else begin
						req.rd_en   = 1'b1;
						req.rd_addr = slot;
						state_d     = S_RMW;
					end
				end
			end
			S_SCAN: begin
				if (rd_data.cnt == '0) begin
					upd.cnt     = COUNT_W'(1);
					req.wr_en   = 1'b1;
					req.wr_addr = cur_q;
					req.wr_data = upd;
					hint_d      = HINT_W'(cur_q) + HINT_W'(1);
					res_vld     = 1'b1;
					res_slot    = cur_q;
					res_flags   = rd_data.flags;
					state_d     = S_IDLE;
				end else if (cur_q == LAST_SLOT) begin
					hint_d     = HINT_FULL;
					res_vld    = 1'b1;
					res_status = ST_FULL;
					res_slot   = '0;
					state_d    = S_IDLE;
				end else begin
					req.rd_en   = 1'b1;
					req.rd_addr = cur_q + SLOT_W'(1);
					cur_d       = cur_q + SLOT_W'(1);
				end
			end
			S_FULL: begin
				res_vld    = 1'b1;
				res_status = ST_FULL;
				res_slot   = '0;
				state_d    = S_IDLE;
			end
			S_RMW: begin
				res_vld = 1'b1;
				state_d = S_IDLE;
				if (out_range) begin
					res_status = known_op ? ST_NOT_USED : ST_OK;
				end else if (known_op && rd_data.cnt == '0) begin
					res_status = ST_NOT_USED;
					res_flags  = rd_data.flags;
				end else begin
					case (op_q)
						OP_FILL: begin
							upd.flags = fin_q & open_mask_q;
						end
						OP_RETAIN: begin
							if (rd_data.cnt == COUNT_MAX) begin
								res_status = ST_OVERFLOW;
							end else begin
								upd.cnt = rd_data.cnt + COUNT_W'(1);
							end
						end
						OP_RELEASE: begin
							upd.cnt = rd_data.cnt - COUNT_W'(1);
							if (upd.cnt == '0) begin
								upd.flags = '0;
								res_freed = 1'b1;
								if (HINT_W'(slot_q) < hint_q) begin
									hint_d = HINT_W'(slot_q);
								end
							end
						end
						OP_SETFL: begin
							upd.flags = (rd_data.flags & keep_mask_q) |
								(fin_q & ~keep_mask_q);
						end
						default: begin
						end
					endcase
					req.wr_en   = known_op;
					req.wr_addr = slot_q;
					req.wr_data = upd;
					res_flags   = upd.flags;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			hint_q      <= '0;
			done_q      <= 1'b0;
			keep_mask_q <= ACCMODE_BITS;
			open_mask_q <= ACCMODE_BITS | NONBLOCK_BIT;
		end else begin
			state_q <= state_d;
			hint_q  <= hint_d;
			done_q  <= res_vld;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_KEEP_MASK: keep_mask_q <= cfg_data;
					CFG_OPEN_MASK: open_mask_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		if (accept) begin
			op_q   <= op;
			slot_q <= slot;
			fin_q  <= flags_in;
		end
		if (res_vld) begin
			status_q   <= res_status;
			slot_out_q <= res_slot;
			flags_q    <= res_flags;
			freed_q    <= res_freed;
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign slot_out  = slot_out_q;
	assign flags_out = flags_q;
	assign freed     = freed_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted item did not raise busy");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q) != S_IDLE)
		else $error("result without work");

	a_full_hint: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && status_q == ST_FULL |-> hint_q == HINT_FULL && flags_q == '0)
		else $error("table full but hint below top");

	a_freed_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && freed_q |-> status_q == ST_OK && flags_q == '0)
		else $error("freed slot with bad status or flags");

endmodule

FILE: sv/refcounted_slot_allocator_top.sv
// Top level of the refcounted slot allocator.
//
//  channel   signals                               handshake
//  --------  ------------------------------------  ---------------------------
//  command   op, slot, flags_in                    start && !busy
//  result    status, slot_out, flags_out, freed    done, one cycle, no stall
//  config    cfg_index, cfg_data                   cfg_valid && cfg_ready
//
//  Non-alloc ops: busy in S_RMW (table read), done on the cycle after.
//  Alloc: busy in S_SCAN while the single table read port walks the slots from the hint,
//  examining 1 to TABLE_SLOTS of them; busy in S_FULL alone when the hint is at the top.
//  Reset clears the table through per-slot valid bits; no clearing pass.
//  Results cannot be held off; a new item may start while done is high.
module refcounted_slot_allocator_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [rsa_pkg::OP_W-1:0]        op,
	input  logic [rsa_pkg::SLOT_W-1:0]      slot,
	input  logic [rsa_pkg::FLAG_BITS-1:0]   flags_in,
	output logic                            done,
	output logic [rsa_pkg::STATUS_W-1:0]    status,
	output logic [rsa_pkg::SLOT_W-1:0]      slot_out,
	output logic [rsa_pkg::FLAG_BITS-1:0]   flags_out,
	output logic                            freed,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rsa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rsa_pkg::FLAG_BITS-1:0]   cfg_data
);
	import rsa_pkg::*;

	mem_req_t req;
	entry_t   rd_data;

	rsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.op        (op),
		.slot      (slot),
		.flags_in  (flags_in),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.rd_data   (rd_data),
		.done      (done),
		.status    (status),
		.slot_out  (slot_out),
		.flags_out (flags_out),
		.freed     (freed)
	);

	rsa_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_data)
	);

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the refcounted slot allocator: driver, monitor and predictor.
`timescale 1ns / 100ps

module testbench;
	import rsa_pkg::*;

	localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;
	localparam int HOG_SLOT = 5;

	typedef struct packed {
		logic [OP_W-1:0]      op;
		logic [SLOT_W-1:0]    slot;
		logic [FLAG_BITS-1:0] flags_in;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [SLOT_W-1:0]    slot_out;
		logic [FLAG_BITS-1:0] flags_out;
		logic                 freed;
	} slot_res_t;

	typedef enum logic [1:0] {PL_CMD, PL_CFG, PL_DRAIN} plan_kind_t;

	typedef struct {
		plan_kind_t           kind;
		cmd_t                 cmd;
		logic [CFG_IDX_W-1:0] cfg_idx;
		logic [FLAG_BITS-1:0] cfg_data;
		int                   gap;
	} plan_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   busy;
	logic [OP_W-1:0]        op = '0;
	logic [SLOT_W-1:0]      slot = '0;
	logic [FLAG_BITS-1:0]   flags_in = '0;
	logic                   done;
	logic [STATUS_W-1:0]    status;
	logic [SLOT_W-1:0]      slot_out;
	logic [FLAG_BITS-1:0]   flags_out;
	logic                   freed;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [FLAG_BITS-1:0]   cfg_data = '0;

	// predictor state
	logic [COUNT_W-1:0]     use_cnt [TABLE_SLOTS] = '{default: '0};
	logic [FLAG_BITS-1:0]   flag_word [TABLE_SLOTS] = '{default: '0};
	int                     lo_free = 0;
	logic [FLAG_BITS-1:0]   keep_bits = ACCMODE_BITS;
	logic [FLAG_BITS-1:0]   open_bits = ACCMODE_BITS | NONBLOCK_BIT;
	slot_res_t              slot_results_due [$];

	// stimulus planning
	plan_t                  plan_q [$];
	int                     plan_cnt [TABLE_SLOTS] = '{default: 0};
	plan_t                  cur;
	logic                   have_cur = 1'b0;
	int                     gap_left = 0;
	int                     quiet = 0;
	logic                   cmd_took = 1'b0;
	logic                   cfg_took = 1'b0;
	int                     errs = 0;

	refcounted_slot_allocator_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.op        (op),
		.slot      (slot),
		.flags_in  (flags_in),
		.done      (done),
		.status    (status),
		.slot_out  (slot_out),
		.flags_out (flags_out),
		.freed     (freed),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic slot_res_t predict_slot_op(cmd_t c);
		slot_res_t r;
		int i;
		r = '{ST_OK, c.slot, '0, 1'b0};
		if (c.op == OP_ALLOC) begin
			i = lo_free;
			while (i < TABLE_SLOTS && use_cnt[i] != '0)
				i++;
			if (i < TABLE_SLOTS) begin
				use_cnt[i] = COUNT_W'(1);
				lo_free = i + 1;
				r.slot_out = SLOT_W'(i);
				r.flags_out = flag_word[i];
			end else begin
				lo_free = TABLE_SLOTS;
				r.status = ST_FULL;
				r.slot_out = '0;
			end
		end else if (c.op <= OP_SETFL && use_cnt[c.slot] == '0) begin
			r.status = ST_NOT_USED;
			r.flags_out = flag_word[c.slot];
		end else begin
			case (c.op)
				OP_FILL: flag_word[c.slot] = c.flags_in & open_bits;
				OP_RETAIN: begin
					if (use_cnt[c.slot] == COUNT_MAX)
						r.status = ST_OVERFLOW;
					else
						use_cnt[c.slot]++;
				end
				OP_RELEASE: begin
					use_cnt[c.slot]--;
					if (use_cnt[c.slot] == '0) begin
						flag_word[c.slot] = '0;
						r.freed = 1'b1;
						if (int'(c.slot) < lo_free)
							lo_free = int'(c.slot);
					end
				end
				OP_SETFL: flag_word[c.slot] = (flag_word[c.slot] & keep_bits) |
					(c.flags_in & ~keep_bits);
				default: ;
			endcase
			r.flags_out = flag_word[c.slot];
		end
		return r;
	endfunction

	function automatic void log_mismatch(string msg);
		errs++;
		if (errs <= 10)
			$display("%0t: %s", $time, msg);
	endfunction

	function automatic void queue_cmd(logic [OP_W-1:0] o, int s, logic [FLAG_BITS-1:0] f,
		int gap);
		plan_t e;
		int i;
		e.kind = PL_CMD;
		e.cmd = '{o, SLOT_W'(s), f};
		e.cfg_idx = '0;
		e.cfg_data = '0;
		e.gap = gap;
		plan_q.push_back(e);
		case (o)
			OP_ALLOC: begin
				i = 0;
				while (i < TABLE_SLOTS && plan_cnt[i] != 0)
					i++;
				if (i < TABLE_SLOTS)
					plan_cnt[i] = 1;
			end
			OP_RETAIN: if (plan_cnt[s] != 0 && plan_cnt[s] < 'hFFFF) plan_cnt[s]++;
			OP_RELEASE: if (plan_cnt[s] != 0) plan_cnt[s]--;
			default: ;
		endcase
	endfunction

	function automatic void queue_ctl(plan_kind_t k, logic [CFG_IDX_W-1:0] idx,
		logic [FLAG_BITS-1:0] d);
		plan_t e;
		e.kind = k;
		e.cmd = '0;
		e.cfg_idx = idx;
		e.cfg_data = d;
		e.gap = 0;
		plan_q.push_back(e);
	endfunction

	function automatic int pick_held_slot();
		int n;
		int k;
		n = 0;
		foreach (plan_cnt[i])
			if (plan_cnt[i] != 0)
				n++;
		if (n == 0)
			return -1;
		k = $urandom_range(n - 1);
		foreach (plan_cnt[i]) begin
			if (plan_cnt[i] != 0) begin
				if (k == 0)
					return i;
				k--;
			end
		end
		return -1;
	endfunction

	function automatic int idle_gap(int pct);
		return ($urandom_range(99) < pct) ? int'($urandom_range(10, 1)) : 0;
	endfunction

	// driver
	always @(negedge clk) begin : drive
		logic nx_start;
		logic nx_cfg;
		nx_start = start;
		nx_cfg = cfg_valid;
		if (arst_n) begin
			if (start && cmd_took)
				nx_start = 1'b0;
			if (cfg_valid && cfg_took)
				nx_cfg = 1'b0;
			quiet = (slot_results_due.size() == 0 && !busy && !done) ? quiet + 1 : 0;
			if (!nx_start && !nx_cfg) begin
				if (!have_cur && plan_q.size() != 0) begin
					cur = plan_q.pop_front();
					have_cur = 1'b1;
					gap_left = cur.gap;
				end
				if (have_cur) begin
					if (gap_left != 0) begin
						gap_left--;
					end else begin
						case (cur.kind)
							PL_CMD: begin
								nx_start = 1'b1;
								op <= cur.cmd.op;
								slot <= cur.cmd.slot;
								flags_in <= cur.cmd.flags_in;
								have_cur = 1'b0;
							end
							PL_CFG: begin
								nx_cfg = 1'b1;
								cfg_index <= cur.cfg_idx;
								cfg_data <= cur.cfg_data;
								have_cur = 1'b0;
							end
							default: begin
								if (quiet >= 4)
									have_cur = 1'b0;
							end
						endcase
					end
				end
			end
		end
		start <= nx_start;
		cfg_valid <= nx_cfg;
	end

	// monitor and prediction
	always @(posedge clk) begin : watch
		slot_res_t want;
		cmd_t c;
		cmd_took = arst_n && start && !busy;
		cfg_took = arst_n && cfg_valid && cfg_ready;
		if (arst_n && done) begin
			if (slot_results_due.size() == 0) begin
				log_mismatch($sformatf("unexpected result: status %0d slot %0d flags %h freed %b",
					status, slot_out, flags_out, freed));
			end else begin
				want = slot_results_due.pop_front();
				if (status !== want.status || slot_out !== want.slot_out ||
					flags_out !== want.flags_out || freed !== want.freed)
					log_mismatch($sformatf({"result mismatch: expected status %0d slot %0d ",
						"flags %h freed %b, got status %0d slot %0d flags %h freed %b"},
						want.status, want.slot_out, want.flags_out, want.freed,
						status, slot_out, flags_out, freed));
			end
		end
		if (cmd_took) begin
			c = '{op, slot, flags_in};
			slot_results_due.push_back(predict_slot_op(c));
		end
		if (cfg_took) begin
			case (cfg_index)
				CFG_KEEP_MASK: keep_bits = cfg_data;
				CFG_OPEN_MASK: open_bits = cfg_data;
				default: ;
			endcase
		end
	end

	initial begin : stim
		int s;
		int r;
		int hold;
		int gp;
		int a_pct;
		int gp_pct;
		int n;
		logic [OP_W-1:0] o;
		logic [FLAG_BITS-1:0] kv;
		logic [FLAG_BITS-1:0] ov;

		// ops on free slots, reserved ops
		queue_cmd(OP_FILL, 0, 16'hFFFF, 0);
		queue_cmd(OP_RETAIN, 0, '0, 0);
		queue_cmd(OP_RELEASE, 63, '0, 0);
		queue_cmd(OP_GETFL, 63, '0, 0);
		queue_cmd(OP_SETFL, 0, 16'hFFFF, 1);
		queue_cmd(OP_RSVD_6, 63, 16'hFFFF, 0);
		queue_cmd(OP_RSVD_7, 0, '0, 0);
		// one slot through its life
		queue_cmd(OP_ALLOC, 63, 16'hFFFF, 0);
		queue_cmd(OP_FILL, 0, 16'hFFFF, 0);
		queue_cmd(OP_GETFL, 0, '0, 0);
		queue_cmd(OP_SETFL, 0, 16'hFFFF, 0);
		queue_cmd(OP_SETFL, 0, 16'h0000, 0);
		queue_cmd(OP_RSVD_6, 0, '0, 0);
		queue_cmd(OP_RETAIN, 0, '0, 0);
		queue_cmd(OP_RELEASE, 0, '0, 0);
		queue_cmd(OP_RELEASE, 0, '0, 0);
		queue_cmd(OP_RELEASE, 0, '0, 0);
		// hint moves down on free
		queue_cmd(OP_ALLOC, 0, '0, 0);
		queue_cmd(OP_ALLOC, 0, '0, 2);
		queue_cmd(OP_ALLOC, 0, '0, 0);
		queue_cmd(OP_FILL, 1, 16'h5A5A, 0);
		queue_cmd(OP_RELEASE, 1, '0, 0);
		queue_cmd(OP_ALLOC, 0, '0, 0);

		// table full
		for (s = 0; s < TABLE_SLOTS; s++)
			if (plan_cnt[s] == 0)
				queue_cmd(OP_ALLOC, s, '0, idle_gap(20));
		queue_cmd(OP_ALLOC, 0, '0, 0);
		queue_cmd(OP_ALLOC, 0, '0, 0);
		queue_cmd(OP_RELEASE, 37, '0, 0);
		queue_cmd(OP_ALLOC, 0, '0, 0);
		queue_cmd(OP_ALLOC, 0, '0, 0);

		// repeated retains on one slot
		repeat (40)
			queue_cmd(OP_RETAIN, HOG_SLOT, FLAG_BITS'($urandom), 0);
		queue_cmd(OP_RETAIN, HOG_SLOT, '0, 0);
		queue_cmd(OP_RETAIN, HOG_SLOT, '0, 3);
		queue_cmd(OP_GETFL, HOG_SLOT, '0, 0);

		for (s = TABLE_SLOTS - 1; s >= 0; s--)
			if (s != HOG_SLOT)
				while (plan_cnt[s] != 0)
					queue_cmd(OP_RELEASE, s, '0, idle_gap(20));

		for (int p = 0; p < 8; p++) begin
			if (p != 0) begin
				queue_ctl(PL_DRAIN, '0, '0);
				case (p)
					1: begin kv = '0; ov = '1; end
					2: begin kv = '1; ov = '0; end
					4: begin kv = '1; ov = '1; end
					5: begin kv = '0; ov = '0; end
					7: begin kv = ACCMODE_BITS; ov = ACCMODE_BITS | NONBLOCK_BIT; end
					default: begin kv = FLAG_BITS'($urandom); ov = FLAG_BITS'($urandom); end
				endcase
				queue_ctl(PL_CFG, CFG_KEEP_MASK, kv);
				queue_ctl(PL_CFG, CFG_OPEN_MASK, ov);
			end
			a_pct = (p % 2 == 0) ? 65 : 20;
			gp_pct = (p == 3 || p == 7) ? 0 : 15;
			for (int k = 0; k < 120; k++) begin
				r = $urandom_range(99);
				gp = idle_gap(gp_pct);
				hold = pick_held_slot();
				if (r < a_pct || hold < 0) begin
					queue_cmd(OP_ALLOC, $urandom_range(63), FLAG_BITS'($urandom), gp);
				end else if (r < a_pct + 10) begin
					queue_cmd(OP_W'($urandom_range(7)), $urandom_range(63),
						FLAG_BITS'($urandom), gp);
				end else begin
					if ($urandom_range(99) < (100 - a_pct) / 2)
						o = OP_RELEASE;
					else
						case ($urandom_range(3))
							0: o = OP_FILL;
							1: o = OP_RETAIN;
							2: o = OP_GETFL;
							default: o = OP_SETFL;
						endcase
					queue_cmd(o, hold, FLAG_BITS'($urandom), gp);
				end
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (plan_q.size() != 0 || have_cur || start || cfg_valid)
			@(posedge clk);
		for (n = 0; n < 200 && slot_results_due.size() != 0; n++)
			@(posedge clk);
		repeat (4) @(posedge clk);
		errs += slot_results_due.size();
		if (errs == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: files.f
sv/rsa_pkg.sv
sv/rsa_mem.sv
sv/rsa_ctrl.sv
sv/refcounted_slot_allocator_top.sv
tb/sv/testbench.sv
